### sv/smsp_pkg.sv
// smsp_pkg: shared types and constants for the surface map stream parser
// parse phases, record kinds, result record layout and header magic words
// no dependencies
`default_nettype none

package smsp_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned PAYLOAD_W = 192;   // m_tdata width, record kind excluded
    localparam int unsigned KIND_W    = 3;

    localparam logic [WORD_W-1:0] MAGIC_0 = 16'd19533;
    localparam logic [WORD_W-1:0] MAGIC_1 = 16'd19795;
    localparam logic [WORD_W-1:0] MAGIC_2 = 16'd20545;

    // word positions inside the headers
    localparam logic [2:0] MAP_MAGIC_WORDS = 3'd3;
    localparam logic [2:0] MAP_SUM_POS     = 3'd7;
    localparam logic [2:0] FLD_INDEX_POS   = 3'd3;
    localparam logic [2:0] FLD_SUM_POS     = 3'd4;
    localparam logic [1:0] SURF_LAST_WORD  = 2'd3;
    localparam logic [31:0] FLD_HDR_WORDS  = 32'd5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MAP   = 3'd1,
        PH_FIELD = 3'd2,
        PH_CELL  = 3'd3,
        PH_SURF  = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAP_HDR   = 3'd0,
        KIND_FIELD_HDR = 3'd1,
        KIND_SURFACE   = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_MAP_SUM   = 3'd4,
        KIND_MARKER    = 3'd5,
        KIND_FIELD_SUM = 3'd6,
        KIND_MALFORMED = 3'd7
    } kind_t;

    // first member sits in the top bits, so the tdata order runs bottom up
    typedef struct packed {
        kind_t              record_kind;
        logic signed [15:0] surface_type;
        logic signed [15:0] surface_var_height;
        logic signed [15:0] surface_height;
        logic signed [15:0] surface_length;
        logic [15:0]        cell_id;
        logic [31:0]        field_size_words;
        logic signed [15:0] field_index;
        logic signed [15:0] field_count;
        logic signed [15:0] gap_dim;
        logic signed [15:0] cell_dim;
        logic [15:0]        format_version;
    } result_t;

    function automatic logic [WORD_W-1:0] magic_word(input logic [1:0] idx);
        logic [WORD_W-1:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### sv/smsp_parse_core.sv
// smsp_parse_core: per-word parse state update and result record forming
// depends on smsp_pkg
`default_nettype none

module smsp_parse_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [smsp_pkg::WORD_W-1:0]   cfg_wr_data,
    input  wire logic                          in_accept,
    input  wire logic [smsp_pkg::WORD_W-1:0]   in_word,
    input  wire logic                          in_start,
    input  wire logic                          in_end,
    output logic                               res_valid,
    output smsp_pkg::result_t                  res
);

    smsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [31:0] body_reg, body_next;
    logic [15:0] sleft_reg, sleft_next;
    logic [1:0]  sw_reg, sw_next;
    logic [15:0] hdr_reg [4];
    logic [15:0] hdr_next [4];
    logic [15:0] surf_reg [3];
    logic [15:0] surf_next [3];
    logic [15:0] field_reg, field_next;
    logic [15:0] cell_reg, cell_next;
    logic [15:0] marker_reg;

    // state as seen by this beat, after a stream start
    smsp_pkg::phase_t eff_phase;
    logic [2:0]  eff_pos;
    logic [15:0] eff_sum;
    logic [31:0] eff_body;
    logic [15:0] eff_sleft;
    logic [1:0]  eff_sw;

    logic [2:0]  map_idx;
    logic [2:0]  fld_idx;
    logic [31:0] body_dec;
    logic [15:0] sleft_dec;
    logic [31:0] need_words;
    logic [31:0] fsize;
    logic [15:0] sum_add;

    logic            err;
    smsp_pkg::kind_t err_kind;
    logic            rec;

    assign eff_phase = in_start ? smsp_pkg::PH_MAP : phase_reg;
    assign eff_pos   = in_start ? 3'd0  : pos_reg;
    assign eff_sum   = in_start ? 16'd0 : sum_reg;
    assign eff_body  = in_start ? 32'd0 : body_reg;
    assign eff_sleft = in_start ? 16'd0 : sleft_reg;
    assign eff_sw    = in_start ? 2'd0  : sw_reg;

    assign map_idx    = eff_pos - smsp_pkg::MAP_MAGIC_WORDS;
    assign fld_idx    = eff_pos - 3'd1;
    assign body_dec   = eff_body - 32'd1;
    assign sleft_dec  = eff_sleft - 16'd1;
    assign need_words = {14'd0, in_word, 2'b00};
    assign fsize      = {hdr_reg[1], hdr_reg[0]};
    assign sum_add    = eff_sum + in_word;

    // next state
    always_comb begin
        phase_next = eff_phase;
        pos_next   = eff_pos;
        sum_next   = eff_sum;
        body_next  = eff_body;
        sleft_next = eff_sleft;
        sw_next    = eff_sw;
        hdr_next   = hdr_reg;
        surf_next  = surf_reg;
        field_next = field_reg;
        cell_next  = cell_reg;
        err        = 1'b0;
        err_kind   = smsp_pkg::KIND_MALFORMED;
        unique case (eff_phase)
            smsp_pkg::PH_IDLE: begin
            end
            smsp_pkg::PH_MAP: begin
                if (eff_pos < smsp_pkg::MAP_MAGIC_WORDS) begin
                    if (in_word != smsp_pkg::magic_word(eff_pos[1:0])) begin
                        err      = 1'b1;
                        err_kind = smsp_pkg::KIND_BAD_MAGIC;
                    end else begin
                        sum_next = sum_add;
                        pos_next = eff_pos + 3'd1;
                    end
                end else if (eff_pos < smsp_pkg::MAP_SUM_POS) begin
                    hdr_next[map_idx[1:0]] = in_word;
                    sum_next = sum_add;
                    pos_next = eff_pos + 3'd1;
                end else if (eff_sum != in_word) begin
                    err      = 1'b1;
                    err_kind = smsp_pkg::KIND_MAP_SUM;
                end else begin
                    phase_next = smsp_pkg::PH_FIELD;
                    pos_next   = 3'd0;
                    sum_next   = 16'd0;
                end
            end
            smsp_pkg::PH_FIELD: begin
                if (eff_pos == 3'd0) begin
                    if (in_word != marker_reg) begin
                        err      = 1'b1;
                        err_kind = smsp_pkg::KIND_MARKER;
                    end else begin
                        sum_next = 16'd0;
                        pos_next = 3'd1;
                    end
                end else if (eff_pos < smsp_pkg::FLD_SUM_POS) begin
                    if (eff_pos < smsp_pkg::FLD_INDEX_POS) begin
                        hdr_next[fld_idx[1:0]] = in_word;
                    end else begin
                        field_next = in_word;
                    end
                    sum_next = sum_add;
                    pos_next = eff_pos + 3'd1;
                end else if (eff_sum != in_word) begin
                    err      = 1'b1;
                    err_kind = smsp_pkg::KIND_FIELD_SUM;
                end else if (fsize < smsp_pkg::FLD_HDR_WORDS) begin
                    err = 1'b1;
                end else begin
                    pos_next = 3'd0;
                    if (fsize > smsp_pkg::FLD_HDR_WORDS) begin
                        body_next  = fsize - smsp_pkg::FLD_HDR_WORDS;
                        phase_next = smsp_pkg::PH_CELL;
                    end
                end
            end
            smsp_pkg::PH_CELL: begin
                if (eff_pos == 3'd0) begin
                    if (eff_body < 32'd2) begin
                        err = 1'b1;
                    end else begin
                        body_next = body_dec;
                        cell_next = in_word;
                        pos_next  = 3'd1;
                    end
                end else begin
                    body_next = body_dec;
                    if (need_words > body_dec) begin
                        err = 1'b1;
                    end else begin
                        pos_next = 3'd0;
                        if (in_word == 16'd0) begin
                            if (body_dec == 32'd0) begin
                                phase_next = smsp_pkg::PH_FIELD;
                            end
                        end else begin
                            sleft_next = in_word;
                            sw_next    = 2'd0;
                            phase_next = smsp_pkg::PH_SURF;
                        end
                    end
                end
            end
            smsp_pkg::PH_SURF: begin
                body_next = body_dec;
                if (eff_sw != smsp_pkg::SURF_LAST_WORD) begin
                    surf_next[eff_sw] = in_word;
                    sw_next = eff_sw + 2'd1;
                end else begin
                    sw_next    = 2'd0;
                    sleft_next = sleft_dec;
                    if (sleft_dec == 16'd0) begin
                        phase_next = (body_dec == 32'd0) ? smsp_pkg::PH_FIELD
                                                         : smsp_pkg::PH_CELL;
                        pos_next   = 3'd0;
                    end
                end
            end
            default: begin
            end
        endcase
        // last beat must close a whole map header or field
        if (eff_phase != smsp_pkg::PH_IDLE && !err && in_end) begin
            if (!(phase_next == smsp_pkg::PH_FIELD && pos_next == 3'd0)) begin
                err      = 1'b1;
                err_kind = smsp_pkg::KIND_MALFORMED;
            end else begin
                phase_next = smsp_pkg::PH_IDLE;
                pos_next   = 3'd0;
            end
        end
        if (err) begin
            phase_next = smsp_pkg::PH_IDLE;
            pos_next   = 3'd0;
        end
    end

    // result record
    always_comb begin
        res = '0;
        rec = 1'b0;
        if (err) begin
            res.record_kind = err_kind;
        end else begin
            unique case (eff_phase)
                smsp_pkg::PH_MAP: begin
                    if (eff_pos == smsp_pkg::MAP_SUM_POS) begin
                        rec                = 1'b1;
                        res.record_kind    = smsp_pkg::KIND_MAP_HDR;
                        res.format_version = hdr_reg[0];
                        res.cell_dim       = hdr_reg[1];
                        res.gap_dim        = hdr_reg[2];
                        res.field_count    = hdr_reg[3];
                    end
                end
                smsp_pkg::PH_FIELD: begin
                    if (eff_pos == smsp_pkg::FLD_SUM_POS) begin
                        rec                  = 1'b1;
                        res.record_kind      = smsp_pkg::KIND_FIELD_HDR;
                        res.field_index      = field_reg;
                        res.field_size_words = fsize;
                    end
                end
                smsp_pkg::PH_SURF: begin
                    if (eff_sw == smsp_pkg::SURF_LAST_WORD) begin
                        rec                    = 1'b1;
                        res.record_kind        = smsp_pkg::KIND_SURFACE;
                        res.field_index        = field_reg;
                        res.cell_id            = cell_reg;
                        res.surface_length     = surf_reg[0];
                        res.surface_height     = surf_reg[1];
                        res.surface_var_height = surf_reg[2];
                        res.surface_type       = in_word;
                    end
                end
                default: begin
                end
            endcase
        end
        res_valid = in_accept && (err || rec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= smsp_pkg::PH_IDLE;
            pos_reg    <= 3'd0;
            sum_reg    <= 16'd0;
            body_reg   <= 32'd0;
            sleft_reg  <= 16'd0;
            sw_reg     <= 2'd0;
            field_reg  <= 16'd0;
            cell_reg   <= 16'd0;
            marker_reg <= 16'd0;
        end else begin
            if (cfg_wr_en) begin
                marker_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                body_reg  <= body_next;
                sleft_reg <= sleft_next;
                sw_reg    <= sw_next;
                field_reg <= field_next;
                cell_reg  <= cell_next;
            end
        end
    end

    // header and surface words: written before read, no reset
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hdr_reg  <= hdr_next;
            surf_reg <= surf_next;
        end
    end

    a_idle_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == smsp_pkg::PH_IDLE |-> pos_reg == 3'd0)
        else $error("idle phase with nonzero word position");

    a_surf_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == smsp_pkg::PH_SURF |-> sleft_reg != 16'd0)
        else $error("surface phase with no surfaces left");

    a_cell_body: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == smsp_pkg::PH_CELL |-> body_reg != 32'd0)
        else $error("cell phase with empty field body");

endmodule

`default_nettype wire

### sv/smsp_out_skid.sv
// smsp_out_skid: result register plus one skid entry toward the master side
// depends on smsp_pkg
`default_nettype none

module smsp_out_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  smsp_pkg::result_t        in_data,
    output logic                     in_ready,
    output logic                     out_valid,
    output smsp_pkg::result_t        out_data,
    input  wire logic                out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    smsp_pkg::result_t out_data_reg;
    smsp_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> in_ready)
        else $error("result offered while skid entry is full");

endmodule

`default_nettype wire

### sv/surface_map_stream_parser_core.sv
// surface_map_stream_parser_core: top level of the surface map word stream parser
// depends on smsp_pkg, smsp_parse_core and smsp_out_skid
//
// channel  dir  ports                          contents
// s_       in   tvalid tready tdata tuser tlast  map word, stream start, stream end
// m_       out  tvalid tready tdata tuser        parsed record, record kind
// cfg_     in   wr_en wr_data                    field start marker
//
// one word per cycle while s_tready is high; each word updates the parse state in the cycle it is taken
// the word that closes a record registers it into the m_ output register, or into the skid entry while m_ stalls
// s_tready drops only while the skid entry holds a record behind a stalled m_
// aresetn is synchronous, active low; parser comes up idle, marker register zero
// words are ignored until one arrives with s_tuser set (stream start)
`default_nettype none

module surface_map_stream_parser_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [smsp_pkg::WORD_W-1:0]    cfg_wr_data,   // field_start_marker
    // word stream in
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [smsp_pkg::WORD_W-1:0]    s_tdata,       // [15:0] stream_word
    input  wire logic                           s_tuser,       // [0] stream_start
    input  wire logic                           s_tlast,       // stream_end
    // records out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [15:0] format_version, [31:16] cell_dim, [47:32] gap_dim,
    // [63:48] field_count, [79:64] field_index, [111:80] field_size_words,
    // [127:112] cell_id, [143:128] surface_length, [159:144] surface_height,
    // [175:160] surface_var_height, [191:176] surface_type
    output logic [smsp_pkg::PAYLOAD_W-1:0]      m_tdata,
    output logic [smsp_pkg::KIND_W-1:0]         m_tuser        // [2:0] record_kind
);

    logic              s_beat;        // input beat taken this cycle
    logic              res_valid;
    smsp_pkg::result_t res;
    logic              skid_ready;
    smsp_pkg::result_t out_rec;

    assign s_tready = skid_ready;
    assign s_beat   = s_tvalid && s_tready;

    // parse state and record build
    smsp_parse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (s_beat),
        .in_word     (s_tdata),
        .in_start    (s_tuser),
        .in_end      (s_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register with skid entry, keeps the word side moving under a stall until the skid entry fills
    smsp_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (skid_ready),
        .out_valid (m_tvalid),
        .out_data  (out_rec),
        .out_ready (m_tready)
    );

    assign m_tdata = out_rec[smsp_pkg::PAYLOAD_W-1:0];
    assign m_tuser = out_rec.record_kind;

endmodule

`default_nettype wire

### test/surface_map_stream_parser_core_test.sv
// surface_map_stream_parser_core_test: self-checking bench for the surface map word parser
// drives map word streams on s_, checks every record on m_ against a built-in parser model
// depends on smsp_pkg and surface_map_stream_parser_core
module surface_map_stream_parser_core_test;
    import smsp_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles without any beat before the run is called hung
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off that backs up the input
    localparam int PHASE_WORDS = 100;    // minimum parsed words per random phase

    // one beat of the word stream
    typedef struct packed {
        logic [15:0] word;
        logic        first;
        logic        last;
    } beat_t;

    // directed row: pinned rows carry an expectation typed in by hand
    typedef struct packed {
        logic [15:0] word;
        logic        first;
        logic        last;
        logic        pinned;
        logic        pin_has;
        kind_t       pin_kind;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [WORD_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;       // [15:0] stream_word
    logic                 s_tuser;       // [0] stream_start
    logic                 s_tlast;       // stream_end
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PAYLOAD_W-1:0] m_tdata;       // [15:0] format_version ... [191:176] surface_type
    logic [KIND_W-1:0]    m_tuser;       // [2:0] record_kind

    surface_map_stream_parser_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // parser model state, mirrors the block
    phase_t      ph = PH_IDLE;
    logic [2:0]  pos = '0;
    logic [15:0] rsum = '0;
    logic [31:0] body_left = '0;
    logic [15:0] surf_left = '0;
    logic [1:0]  surf_pos = '0;
    logic [15:0] hdr_words [0:3];
    logic [15:0] surf_words [0:2];
    logic [15:0] cur_field = '0;
    logic [15:0] cur_cell = '0;
    logic [15:0] field_marker = '0;

    result_t     records_due [$];        // records the block still owes, oldest first
    beat_t       stream_beats [$];
    logic [15:0] field_body [$];
    dir_row_t    dir_rows [$];

    int errors = 0;
    int words_parsed = 0;
    int records_checked = 0;
    int streams_sent = 0;
    int burst_left = 0;
    bit hold_off_req = 0;

    // one word through the parser model; got is set when the word yields a record,
    // live when the parser was not idle or halted
    task automatic parse_word(input logic [15:0] w, input logic first, input logic last,
                              output bit got, output result_t rec, output bit live);
        logic [15:0] magic;
        logic [31:0] fsize;
        bit          bad;
        kind_t       bad_kind;
        got = 0;
        live = 0;
        bad = 0;
        bad_kind = KIND_MALFORMED;
        rec = '0;
        if (first) begin
            ph = PH_MAP;
            pos = '0;
            rsum = '0;
            body_left = '0;
            surf_left = '0;
            surf_pos = '0;
        end
        if (ph != PH_IDLE) begin
            live = 1;
            case (ph)
                PH_MAP: begin
                    case (pos)
                        3'd0:    magic = MAGIC_0;
                        3'd1:    magic = MAGIC_1;
                        default: magic = MAGIC_2;
                    endcase
                    if (pos < 3'd3 && w != magic) begin
                        bad = 1;
                        bad_kind = KIND_BAD_MAGIC;
                    end else if (pos == 3'd7) begin
                        if (w != rsum) begin
                            bad = 1;
                            bad_kind = KIND_MAP_SUM;
                        end else begin
                            rec.record_kind = KIND_MAP_HDR;
                            rec.format_version = hdr_words[0];
                            rec.cell_dim = hdr_words[1];
                            rec.gap_dim = hdr_words[2];
                            rec.field_count = hdr_words[3];
                            got = 1;
                            ph = PH_FIELD;
                            pos = '0;
                            rsum = '0;
                        end
                    end else begin
                        if (pos >= 3'd3)
                            hdr_words[pos - 3'd3] = w;
                        rsum = rsum + w;
                        pos = pos + 3'd1;
                    end
                end
                PH_FIELD: begin
                    if (pos == 3'd0) begin
                        if (w != field_marker) begin
                            bad = 1;
                            bad_kind = KIND_MARKER;
                        end else begin
                            rsum = '0;
                            pos = 3'd1;
                        end
                    end else if (pos < 3'd4) begin
                        if (pos < 3'd3)
                            hdr_words[pos - 3'd1] = w;
                        else
                            cur_field = w;
                        rsum = rsum + w;
                        pos = pos + 3'd1;
                    end else if (w != rsum) begin
                        bad = 1;
                        bad_kind = KIND_FIELD_SUM;
                    end else begin
                        fsize = {hdr_words[1], hdr_words[0]};
                        if (fsize < 32'd5) begin
                            bad = 1;
                            bad_kind = KIND_MALFORMED;
                        end else begin
                            rec.record_kind = KIND_FIELD_HDR;
                            rec.field_index = cur_field;
                            rec.field_size_words = fsize;
                            got = 1;
                            pos = '0;
                            if (fsize > 32'd5) begin
                                body_left = fsize - 32'd5;
                                ph = PH_CELL;
                            end
                        end
                    end
                end
                PH_CELL: begin
                    if (pos == 3'd0) begin
                        if (body_left < 32'd2) begin
                            bad = 1;
                            bad_kind = KIND_MALFORMED;
                        end else begin
                            body_left = body_left - 32'd1;
                            cur_cell = w;
                            pos = 3'd1;
                        end
                    end else begin
                        body_left = body_left - 32'd1;
                        if ({14'd0, w, 2'b00} > body_left) begin
                            bad = 1;
                            bad_kind = KIND_MALFORMED;
                        end else begin
                            pos = '0;
                            if (w == 16'd0) begin
                                if (body_left == 32'd0)
                                    ph = PH_FIELD;
                            end else begin
                                surf_left = w;
                                surf_pos = '0;
                                ph = PH_SURF;
                            end
                        end
                    end
                end
                default: begin
                    body_left = body_left - 32'd1;
                    if (surf_pos < 2'd3) begin
                        surf_words[surf_pos] = w;
                        surf_pos = surf_pos + 2'd1;
                    end else begin
                        rec.record_kind = KIND_SURFACE;
                        rec.field_index = cur_field;
                        rec.cell_id = cur_cell;
                        rec.surface_length = surf_words[0];
                        rec.surface_height = surf_words[1];
                        rec.surface_var_height = surf_words[2];
                        rec.surface_type = w;
                        got = 1;
                        surf_pos = '0;
                        surf_left = surf_left - 16'd1;
                        if (surf_left == 16'd0) begin
                            if (body_left == 32'd0)
                                ph = PH_FIELD;
                            else
                                ph = PH_CELL;
                            pos = '0;
                        end
                    end
                end
            endcase
            // stream end is fine only on a field boundary; an error in the word wins
            if (!bad && last) begin
                if (ph == PH_FIELD && pos == 3'd0) begin
                    ph = PH_IDLE;
                end else begin
                    bad = 1;
                    bad_kind = KIND_MALFORMED;
                end
            end
            if (bad) begin
                rec = '0;
                rec.record_kind = bad_kind;
                got = 1;
                ph = PH_IDLE;
                pos = '0;
            end
        end
    endtask

    // offer one beat in bursts with random gaps, then run it through the model
    task automatic send_beat(input logic [15:0] w, input logic first, input logic last,
                             input bit pinned, input bit pin_has, input kind_t pin_kind);
        result_t rec;
        bit      got;
        bit      live;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= first;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        parse_word(w, first, last, got, rec, live);
        if (live)
            words_parsed++;
        if (pinned) begin
            got = pin_has;
            rec = '0;
            rec.record_kind = pin_kind;
        end
        if (got)
            records_due.insert(records_due.size(), rec);
    endtask

    // stop sending, let every owed record arrive, then let the clock run on idle
    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        while (records_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_marker(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        field_marker = value;
    endtask

    function automatic void add_row(input logic [15:0] w, input logic first, input logic last,
                                    input logic pinned, input logic pin_has, input kind_t k);
        dir_row_t r;
        r.word = w;
        r.first = first;
        r.last = last;
        r.pinned = pinned;
        r.pin_has = pin_has;
        r.pin_kind = k;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // one random stream: mostly well formed, with a share of broken headers,
    // bad sizes, overruns and cut-off ends
    task automatic compose_stream();
        logic [15:0] map_hdr [0:7];
        logic [15:0] sum;
        logic [15:0] idx;
        logic [15:0] mk;
        logic [31:0] fsize;
        beat_t       b;
        int          nf;
        int          ncell;
        int          cnt;
        int          fv;
        int          ev;
        int          cut;
        stream_beats.delete();
        // stray words ahead of the start are ignored when the parser is idle
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3))
                stream_beats.insert(stream_beats.size(), {16'($urandom), 1'b0, 1'b0});
        end

        map_hdr[0] = MAGIC_0;
        map_hdr[1] = MAGIC_1;
        map_hdr[2] = MAGIC_2;
        for (int i = 3; i < 7; i++)
            map_hdr[i] = 16'($urandom);
        sum = '0;
        for (int i = 0; i < 7; i++)
            sum = sum + map_hdr[i];
        map_hdr[7] = sum;
        case ($urandom_range(0, 19))
            0: begin
                cnt = $urandom_range(0, 2);
                map_hdr[cnt] = map_hdr[cnt] ^ (16'd1 << $urandom_range(0, 15));
            end
            1: map_hdr[7] = map_hdr[7] ^ 16'($urandom_range(1, 65535));
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
            stream_beats.insert(stream_beats.size(),
                                {map_hdr[i], (i == 0) ? 1'b1 : 1'b0, 1'b0});

        nf = $urandom_range(0, 3);
        for (int f = 0; f < nf; f++) begin
            field_body.delete();
            ncell = $urandom_range(0, 3);
            for (int c = 0; c < ncell; c++) begin
                field_body.insert(field_body.size(), 16'($urandom));
                cnt = $urandom_range(0, 3);
                field_body.insert(field_body.size(), 16'(cnt));
                repeat (4 * cnt)
                    field_body.insert(field_body.size(), 16'($urandom));
            end
            fv = $urandom_range(0, 24);
            // last cell with a count the body cannot hold
            if (fv == 6) begin
                field_body.insert(field_body.size(), 16'($urandom));
                field_body.insert(field_body.size(), 16'($urandom_range(1, 65535)));
            end
            // stray word counted in the size: a cell index with one word left
            if (fv == 4)
                field_body.insert(field_body.size(), 16'($urandom));
            fsize = 32'd5 + 32'(field_body.size());
            if (fv == 2)
                fsize = 32'($urandom_range(0, 4));
            if (fv == 3 && fsize > 32'd5)
                fsize = fsize - 32'($urandom_range(1, 3));
            if (fv == 5)
                fsize[31:16] = 16'($urandom_range(1, 65535));
            idx = 16'($urandom);
            sum = fsize[15:0] + fsize[31:16] + idx;
            if (fv == 1)
                sum = sum ^ 16'($urandom_range(1, 65535));
            mk = field_marker;
            if (fv == 0)
                mk = mk ^ 16'($urandom_range(1, 65535));
            stream_beats.insert(stream_beats.size(), {mk, 1'b0, 1'b0});
            stream_beats.insert(stream_beats.size(), {fsize[15:0], 1'b0, 1'b0});
            stream_beats.insert(stream_beats.size(), {fsize[31:16], 1'b0, 1'b0});
            stream_beats.insert(stream_beats.size(), {idx, 1'b0, 1'b0});
            stream_beats.insert(stream_beats.size(), {sum, 1'b0, 1'b0});
            foreach (field_body[i])
                stream_beats.insert(stream_beats.size(), {field_body[i], 1'b0, 1'b0});
        end

        // ending: cut short without end flag, cut short with end flag, or whole
        ev = $urandom_range(0, 9);
        if (ev <= 1 && stream_beats.size() > 1) begin
            cut = (stream_beats.size() - 1 < 6) ? stream_beats.size() - 1 : 6;
            cut = $urandom_range(1, cut);
            repeat (cut)
                b = stream_beats.pop_back();
        end
        if (ev != 0) begin
            b = stream_beats.pop_back();
            b.last = 1'b1;
            stream_beats.insert(stream_beats.size(), b);
        end
    endtask

    // record checker: every accepted record against the oldest owed one
    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t record field %s: expected %0h, actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    result_t mon_exp;
    result_t mon_got;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = {m_tuser, m_tdata};
            if (records_due.size() == 0) begin
                $display("%0t unexpected record: expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                mon_exp = records_due.pop_front();
                check_field("record_kind", mon_exp.record_kind, mon_got.record_kind);
                check_field("format_version", mon_exp.format_version, mon_got.format_version);
                check_field("cell_dim", mon_exp.cell_dim, mon_got.cell_dim);
                check_field("gap_dim", mon_exp.gap_dim, mon_got.gap_dim);
                check_field("field_count", mon_exp.field_count, mon_got.field_count);
                check_field("field_index", mon_exp.field_index, mon_got.field_index);
                check_field("field_size_words", mon_exp.field_size_words,
                            mon_got.field_size_words);
                check_field("cell_id", mon_exp.cell_id, mon_got.cell_id);
                check_field("surface_length", mon_exp.surface_length, mon_got.surface_length);
                check_field("surface_height", mon_exp.surface_height, mon_got.surface_height);
                check_field("surface_var_height", mon_exp.surface_var_height,
                            mon_got.surface_var_height);
                check_field("surface_type", mon_exp.surface_type, mon_got.surface_type);
                records_checked++;
            end
        end
    end

    // receiver: stretches of always ready, coin flip, mostly stalled and toggling,
    // plus one long hold-off on request
    initial begin : receiver
        int mode;
        int left;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(5, 60);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // watchdog: ends the run when no beat moves on any port for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t no beat for %0d cycles, %0d records still owed",
                 $time, STALL_LIMIT, records_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        dir_row_t    row;
        logic [15:0] mk;
        int          target;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, marker still at its reset value of zero
        // word, start, end, pinned, pinned record present, pinned kind
        add_row(16'h1234, 1'b0, 1'b0, 1'b1, 1'b0, KIND_MAP_HDR);    // idle after reset: ignored
        add_row(MAGIC_0,  1'b1, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, KIND_BAD_MAGIC);  // second magic word wrong
        // map header with extreme values: version ffff, cell size most negative,
        // gap size most positive, field count zero
        add_row(MAGIC_0,  1'b1, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(MAGIC_1,  1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(MAGIC_2,  1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'hE9DF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);    // wrapped sum
        // empty field of exactly five words, most negative index
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h0005, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h8005, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        // field of eleven words, most positive index
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h000B, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'h800A, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);    // cell index ffff
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);    // zero count: no record
        add_row(16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, KIND_MAP_HDR);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, KIND_MALFORMED);  // count overruns the body
        add_row(MAGIC_0,  1'b1, 1'b1, 1'b1, 1'b1, KIND_MALFORMED);  // stream ends in map header
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_beat(row.word, row.first, row.last, row.pinned, row.pin_has, row.pin_kind);
        end

        // random phases, each under its own start marker; the first one also
        // holds the receiver off long enough to back the input up
        for (int p = 0; p < 4; p++) begin
            wait_for_quiet();
            case (p)
                0:       mk = 16'hFFFF;
                3:       mk = 16'h0000;
                default: mk = 16'($urandom_range(1, 16'hFFFE));
            endcase
            load_marker(mk);
            if (p == 0)
                hold_off_req = 1;
            target = words_parsed + PHASE_WORDS;
            while (words_parsed < target) begin
                compose_stream();
                foreach (stream_beats[i])
                    send_beat(stream_beats[i].word, stream_beats[i].first,
                              stream_beats[i].last, 1'b0, 1'b0, KIND_MAP_HDR);
                streams_sent++;
            end
        end
        wait_for_quiet();

        $display("run covered %0d parsed map words in %0d random streams", words_parsed,
                 streams_sent);
        $display("%0d records checked over four start marker settings", records_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
